// ----- design/rbsi_pkg.sv -----
`default_nettype none
package rbsi_pkg;

  // Q16.16 coordinates and slab parameters.
  localparam int unsigned QW = 32;
  // The numerator (bound - origin) * 2^16 is 33 + 16 bits wide.
  localparam int unsigned NUMW = QW + 1 + 16;

  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  // Divider latency: magnitude stage, one stage per quotient bit, saturation stage.
  localparam int unsigned DIV_LAT = NUMW + 2;
  // Latency of the interval combine unit.
  localparam int unsigned CMB_LAT = 3;

  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } cfg_reg_t;

  // Per-ray flags that travel beside the dividers.
  typedef struct packed {
    logic [2:0] zero;  // direction component is zero on that axis
    logic       pass;  // every zero-direction axis has its origin inside the bounds
  } side_t;

endpackage
`default_nettype wire

// ----- design/rbsi_ray_if.sv -----
`default_nettype none
interface rbsi_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] direction_x;
  logic signed [31:0] direction_y;
  logic signed [31:0] direction_z;

  modport source (output valid, origin_x, origin_y, origin_z,
                  direction_x, direction_y, direction_z, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z,
                direction_x, direction_y, direction_z, output ready);
endinterface
`default_nettype wire

// ----- design/rbsi_hit_if.sv -----
`default_nettype none
interface rbsi_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface
`default_nettype wire

// ----- design/rbsi_div.sv -----
`default_nettype none
module rbsi_div
  import rbsi_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic signed [NUMW-1:0] num,
  input  wire logic signed [QW-1:0]   den,
  output logic signed [QW-1:0]        quo
);

  // Restoring division on magnitudes, one quotient bit per stage.
  logic [NUMW-1:0] acc [0:NUMW];
  logic [QW-1:0]   rem [0:NUMW];
  logic [QW-1:0]   dm  [0:NUMW];
  logic            ng  [0:NUMW];

  localparam logic [NUMW-1:0] POS_LIM = NUMW'(Q_MAX);
  localparam logic [NUMW-1:0] NEG_LIM = POS_LIM + NUMW'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      acc[0] <= num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
      dm[0]  <= den[QW-1] ? QW'(-den) : QW'(den);
      ng[0]  <= num[NUMW-1] ^ den[QW-1];
      rem[0] <= '0;
    end
  end

  for (genvar k = 0; k < NUMW; k++) begin : g_bit
    logic [QW:0] r2;
    logic        ge;
    assign r2 = {rem[k], acc[k][NUMW-1]};
    assign ge = r2 >= {1'b0, dm[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? QW'(r2 - {1'b0, dm[k]}) : QW'(r2);
        acc[k+1] <= {acc[k][NUMW-2:0], ge};
        dm[k+1]  <= dm[k];
        ng[k+1]  <= ng[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ng[NUMW]) begin
        quo <= (acc[NUMW] > NEG_LIM) ? Q_MIN : QW'(-acc[NUMW]);
      end else begin
        quo <= (acc[NUMW] > POS_LIM) ? Q_MAX : QW'(acc[NUMW]);
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/rbsi_combine.sv -----
`default_nettype none
module rbsi_combine
  import rbsi_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire side_t                side,
  input  wire logic signed [QW-1:0] t0 [0:2],
  input  wire logic signed [QW-1:0] t1 [0:2],
  output logic                      hit
);

  logic signed [QW-1:0] lo_a [0:2];
  logic signed [QW-1:0] hi_a [0:2];
  logic                 pass1;
  logic signed [QW-1:0] lo;
  logic signed [QW-1:0] hi;
  logic                 pass2;
  logic signed [QW-1:0] lo01;
  logic signed [QW-1:0] hi01;

  // Order each axis pair; an axis with zero direction sets no limit.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        if (side.zero[a]) begin
          lo_a[a] <= Q_MIN;
          hi_a[a] <= Q_MAX;
        end else if (t0[a] > t1[a]) begin
          lo_a[a] <= t1[a];
          hi_a[a] <= t0[a];
        end else begin
          lo_a[a] <= t0[a];
          hi_a[a] <= t1[a];
        end
      end
      pass1 <= side.pass;
    end
  end

  assign lo01 = (lo_a[0] > lo_a[1]) ? lo_a[0] : lo_a[1];
  assign hi01 = (hi_a[0] < hi_a[1]) ? hi_a[0] : hi_a[1];

  always_ff @(posedge clk) begin
    if (en) begin
      lo    <= (lo01 > lo_a[2]) ? lo01 : lo_a[2];
      hi    <= (hi01 < hi_a[2]) ? hi01 : hi_a[2];
      pass2 <= pass1;
      hit   <= pass2 && (lo <= hi);
    end
  end

endmodule
`default_nettype wire

// ----- design/ray_box_slab_intersect.sv -----
`default_nettype none
// Ray against axis-aligned box by the slab method. The six box bounds are
// written through the configuration port (indexes 0 to 2 are the x, y and z
// lower bounds, 3 to 5 the upper bounds, all signed Q16.16, reset to zero) and
// must only change while no request is in flight. Each ray request carries a
// Q16.16 origin and direction; for every axis with a nonzero direction the
// block forms (bound - origin) * 2^16 / direction for both bounds, truncated
// toward zero and saturated to the Q16.16 range, orders the pair, and
// intersects the three intervals. An axis with zero direction passes only if
// the origin lies within its bounds, inclusive. Touching intervals count as a
// hit, and there is no t >= 0 test, so boxes behind the origin also hit. The
// block accepts one ray per clock cycle unless the pipeline is stalled and
// returns exactly one hit result per ray in order: the differences are
// registered at the edge that takes the request, then pass through the six
// bit-per-stage dividers (one stage per quotient bit of the 49-bit numerator
// plus magnitude and saturation stages), the interval combine unit and the
// output register.
// A one-entry skid buffer behind the output register lets the pipeline keep
// taking requests while a result waits; the pipeline stalls as a whole only
// once that buffer is full.
module ray_box_slab_intersect
  import rbsi_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  rbsi_ray_if.sink        ray_in,
  rbsi_hit_if.source      hit_out
);

  localparam int unsigned VLAT = DIV_LAT + CMB_LAT;

  // Box bounds, indexed by axis.
  logic signed [QW-1:0] bmin [0:2];
  logic signed [QW-1:0] bmax [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        bmin[a] <= '0;
        bmax[a] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_X: bmin[0] <= cfg_data;
        REG_MIN_Y: bmin[1] <= cfg_data;
        REG_MIN_Z: bmin[2] <= cfg_data;
        REG_MAX_X: bmax[0] <= cfg_data;
        REG_MAX_Y: bmax[1] <= cfg_data;
        REG_MAX_Z: bmax[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves unless the skid buffer holds a result.
  logic skid_full;
  logic skid_hit;
  logic en;
  assign en = !skid_full;
  assign ray_in.ready = en;

  logic signed [QW-1:0] org [0:2];
  logic signed [QW-1:0] dir [0:2];
  assign org[0] = ray_in.origin_x;
  assign org[1] = ray_in.origin_y;
  assign org[2] = ray_in.origin_z;
  assign dir[0] = ray_in.direction_x;
  assign dir[1] = ray_in.direction_y;
  assign dir[2] = ray_in.direction_z;

  // First stage: exact 33-bit differences scaled by 2^16, plus the flags of
  // the zero-direction axes.
  logic signed [NUMW-1:0] num_lo [0:2];
  logic signed [NUMW-1:0] num_hi [0:2];
  logic signed [QW-1:0]   den    [0:2];
  logic                   a_valid;
  side_t                  a_side;
  side_t                  side_next;

  always_comb begin
    side_next.pass = 1'b1;
    for (int a = 0; a < 3; a++) begin
      side_next.zero[a] = (dir[a] == '0);
      if (side_next.zero[a] && (org[a] < bmin[a] || org[a] > bmax[a])) begin
        side_next.pass = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        num_lo[a] <= {({bmin[a][QW-1], bmin[a]} - {org[a][QW-1], org[a]}), 16'd0};
        num_hi[a] <= {({bmax[a][QW-1], bmax[a]} - {org[a][QW-1], org[a]}), 16'd0};
        den[a]    <= dir[a];
      end
      a_side <= side_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= ray_in.valid;
    end
  end

  // Six dividers, the lower and upper slab parameter of each axis.
  logic signed [QW-1:0] t0 [0:2];
  logic signed [QW-1:0] t1 [0:2];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbsi_div u_div_lo (.clk(clk), .en(en), .num(num_lo[a]), .den(den[a]), .quo(t0[a]));
    rbsi_div u_div_hi (.clk(clk), .en(en), .num(num_hi[a]), .den(den[a]), .quo(t1[a]));
  end

  // Flags travel beside the dividers; valid bits also pass the combine unit.
  side_t side_pipe [0:DIV_LAT-1];
  logic  vpipe     [0:VLAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      side_pipe[0] <= a_side;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_pipe[i] <= side_pipe[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VLAT; i++) begin
        vpipe[i] <= 1'b0;
      end
    end else if (en) begin
      vpipe[0] <= a_valid;
      for (int i = 1; i < VLAT; i++) begin
        vpipe[i] <= vpipe[i-1];
      end
    end
  end

  logic p_hit;
  rbsi_combine u_combine (
    .clk (clk),
    .en  (en),
    .side(side_pipe[DIV_LAT-1]),
    .t0  (t0),
    .t1  (t1),
    .hit (p_hit)
  );

  // Output register with a one-entry skid buffer behind it.
  logic out_valid;
  logic out_hit;
  assign hit_out.valid = out_valid;
  assign hit_out.hit   = out_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (hit_out.ready) begin
        out_valid <= 1'b1;
        out_hit   <= skid_hit;
        skid_full <= 1'b0;
      end
    end else if (!out_valid || hit_out.ready) begin
      out_valid <= vpipe[VLAT-1];
      out_hit   <= p_hit;
    end else if (vpipe[VLAT-1]) begin
      skid_hit  <= p_hit;
      skid_full <= 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid buffer holds a result while the output is empty");

  a_stalled_result_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit_out.ready) |=> out_valid)
    else $error("a stalled result was dropped");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_full && hit_out.ready) |=> !skid_full)
    else $error("skid buffer refilled while the pipeline was stalled");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (skid_full && !hit_out.ready) |=> (skid_full && $stable(skid_hit)))
    else $error("skid buffer changed while waiting");
`endif

endmodule
`default_nettype wire

// ----- bench/tb_ray_box_slab_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_ray_box_slab_checker
  import rbsi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  rbsi_ray_if              ray,
  rbsi_hit_if              res,
  output int               fail_count,
  output int               pending
);

  logic signed [31:0] lo_bound [3];
  logic signed [31:0] hi_bound [3];
  bit expected_hits [$];

  function automatic logic signed [63:0] slab_t(input logic signed [31:0] bound,
                                                 input logic signed [31:0] org,
                                                 input logic signed [31:0] dir);
    logic signed [63:0] num;
    logic signed [63:0] q;
    num = (64'(bound) - 64'(org)) * 64'sd65536;
    q = num / 64'(dir);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic bit ray_meets_box(input logic signed [31:0] o [3],
                                       input logic signed [31:0] d [3]);
    logic signed [63:0] enter;
    logic signed [63:0] leave;
    logic signed [63:0] t0;
    logic signed [63:0] t1;
    logic signed [63:0] tmp;
    bit meets;
    enter = -64'sd2147483648;
    leave = 64'sd2147483647;
    meets = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (d[a] == 0) begin
        if (o[a] < lo_bound[a] || o[a] > hi_bound[a]) meets = 1'b0;
      end else begin
        t0 = slab_t(lo_bound[a], o[a], d[a]);
        t1 = slab_t(hi_bound[a], o[a], d[a]);
        if (t0 > t1) begin
          tmp = t0;
          t0 = t1;
          t1 = tmp;
        end
        if (t0 > enter) enter = t0;
        if (t1 < leave) leave = t1;
      end
    end
    if (enter > leave) meets = 1'b0;
    return meets;
  endfunction

  always @(posedge clk) begin
    logic signed [31:0] o [3];
    logic signed [31:0] d [3];
    bit want;
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        lo_bound[a] = '0;
        hi_bound[a] = '0;
      end
      expected_hits.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index <= REG_MIN_Z) lo_bound[cfg_index] = cfg_data;
        else if (cfg_index <= REG_MAX_Z) hi_bound[cfg_index - REG_MAX_X] = cfg_data;
      end
      if (res.valid && res.ready) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected result hit=%0b", $time, res.hit);
          fail_count++;
        end else begin
          want = expected_hits.pop_front();
          if (res.hit !== want) begin
            $display("%0t: hit mismatch expected %0b actual %0b", $time, want, res.hit);
            fail_count++;
          end
        end
      end
      if (ray.valid && ray.ready) begin
        o = '{ray.origin_x, ray.origin_y, ray.origin_z};
        d = '{ray.direction_x, ray.direction_y, ray.direction_z};
        expected_hits.push_back(ray_meets_box(o, d));
      end
      pending <= expected_hits.size();
    end
  end

endmodule
`default_nettype wire

// ----- bench/tb_ray_box_slab_intersect.sv -----
`timescale 1ns / 100ps
`default_nettype none
// Stimulus for the slab intersection block. The checker beside the block
// predicts every hit and compares; this module only drives requests, box
// settings and output stalls, then gives the verdict.
module tb_ray_box_slab_intersect;
  import rbsi_pkg::*;

  localparam int PIPE_DRAIN = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;

  // Idle percentages for the sender and the receiver, set per phase.
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off_cycles = 0;

  logic signed [31:0] box_lo [3];
  logic signed [31:0] box_hi [3];

  rbsi_ray_if ray_ch ();
  rbsi_hit_if hit_ch ();

  always #5 clk = ~clk;

  ray_box_slab_intersect u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .ray_in   (ray_ch.sink),
    .hit_out  (hit_ch.source)
  );

  tb_ray_box_slab_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ray       (ray_ch),
    .res       (hit_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    ray_ch.valid = 1'b0;
    ray_ch.origin_x = '0;
    ray_ch.origin_y = '0;
    ray_ch.origin_z = '0;
    ray_ch.direction_x = '0;
    ray_ch.direction_y = '0;
    ray_ch.direction_z = '0;
    hit_ch.ready = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  // The hold-off is counted here so the sender keeps pushing meanwhile.
  always @(posedge clk) begin
    if (rst) begin
      hit_ch.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      hit_ch.ready <= 1'b0;
    end else begin
      hit_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Write one box register at a clock edge.
  task automatic write_bound(input cfg_reg_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A new box only goes in once the pipeline has drained completely.
  task automatic load_box(input logic signed [31:0] lx, input logic signed [31:0] ly,
                          input logic signed [31:0] lz, input logic signed [31:0] hx,
                          input logic signed [31:0] hy, input logic signed [31:0] hz);
    wait_drained();
    box_lo = '{lx, ly, lz};
    box_hi = '{hx, hy, hz};
    write_bound(REG_MIN_X, lx);
    write_bound(REG_MIN_Y, ly);
    write_bound(REG_MIN_Z, lz);
    write_bound(REG_MAX_X, hx);
    write_bound(REG_MAX_Y, hy);
    write_bound(REG_MAX_Z, hz);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // Offer one request and hold it until the block takes it. Valid stays
  // high between back-to-back requests, so it is only lowered on an idle gap.
  task automatic send_ray(input logic signed [31:0] ox, input logic signed [31:0] oy,
                          input logic signed [31:0] oz, input logic signed [31:0] dx,
                          input logic signed [31:0] dy, input logic signed [31:0] dz);
    while ($urandom_range(99) < send_idle_pct) begin
      ray_ch.valid <= 1'b0;
      @(posedge clk);
    end
    ray_ch.valid <= 1'b1;
    ray_ch.origin_x <= ox;
    ray_ch.origin_y <= oy;
    ray_ch.origin_z <= oz;
    ray_ch.direction_x <= dx;
    ray_ch.direction_y <= dy;
    ray_ch.direction_z <= dz;
    @(posedge clk);
    while (!ray_ch.ready) @(posedge clk);
  endtask

  task automatic end_burst();
    ray_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random coordinate: mostly near the box scale, sometimes fully random,
  // sometimes an extreme or exactly a bound.
  function automatic logic signed [31:0] rand_coord(input int a);
    case ($urandom_range(9))
      0: return $urandom;
      1: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
      2: return box_lo[a];
      3: return box_hi[a];
      default: return $signed($urandom_range(20 << 16)) - (10 <<< 16);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_dir();
    case ($urandom_range(11))
      0, 1: return '0;
      2: return $urandom;
      3: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
      4: return ($urandom_range(1)) ? 32'sh1 : -32'sh1;
      default: return $signed($urandom_range(8 << 16)) - (4 <<< 16);
    endcase
  endfunction

  // Send a burst of rays with a random origin and direction on every axis,
  // then lower valid.
  task automatic random_rays(input int count);
    logic signed [31:0] o [3];
    logic signed [31:0] d [3];
    for (int n = 0; n < count; n++) begin
      for (int a = 0; a < 3; a++) begin
        o[a] = rand_coord(a);
        d[a] = rand_dir();
      end
      send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    end
    end_burst();
  endtask

  initial begin
    box_lo = '{0, 0, 0};
    box_hi = '{0, 0, 0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with the reset box (a point at the origin).
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(1, 0, 0, 0, 0, 0);
    send_ray(-32'sh10000, 0, 0, 32'sh10000, 0, 0);
    end_burst();

    load_box(-32'sh10000, -32'sh10000, -32'sh10000,
             32'sh10000, 32'sh10000, 32'sh10000);
    // Inside, outside, on the bound, behind the origin, touching corner,
    // axis-parallel misses, saturating quotients and extreme fields.
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(32'sh10000, -32'sh10000, 32'sh10000, 0, 0, 0);
    send_ray(32'sh10001, 0, 0, 0, 0, 0);
    send_ray(32'sh50000, 0, 0, 32'sh10000, 0, 0);
    send_ray(-32'sh50000, 0, 0, -32'sh10000, 0, 0);
    send_ray(-32'sh30000, -32'sh10000, 0, 32'sh10000, 0, 0);
    send_ray(-32'sh30000, -32'sh30000, 0, 32'sh10000, 32'sh10000, 0);
    send_ray(-32'sh30000, -32'sh10000, 0, 32'sh10000, 32'sh10000, 0);
    send_ray(-32'sh30000, -32'sh50000, 0, 32'sh10000, 32'sh10000, 0);
    send_ray(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1, -1, 1);
    send_ray(32'sh7fffffff, 0, 0, 32'sh80000000, 32'sh7fffffff, 1);
    send_ray(0, 0, 32'sh7fffffff, 32'shffffffff, 32'sh12345678, 32'sh80000000);
    send_ray(32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa,
             32'sh55555555, 32'shaaaaaaaa, 32'sh55555555);
    end_burst();

    // Inverted bounds and the widest box.
    load_box(32'sh10000, 0, 0, -32'sh10000, 0, 0);
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000);
    end_burst();
    load_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
             32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_ray(32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0);
    send_ray(32'sh7fffffff, 32'sh80000000, 0, -1, 1, 32'sh80000000);
    end_burst();

    // Random phases, each with its own box and idling mix.
    for (int ph = 0; ph < 8; ph++) begin
      logic signed [31:0] p;
      logic signed [31:0] q;
      logic signed [31:0] lo [3];
      logic signed [31:0] hi [3];
      for (int a = 0; a < 3; a++) begin
        p = $signed($urandom_range(16 << 16)) - (8 <<< 16);
        q = $signed($urandom_range(16 << 16)) - (8 <<< 16);
        if (ph == 5) p = $urandom;
        lo[a] = (p < q || ph == 6) ? p : q;
        hi[a] = (p < q || ph == 6) ? q : p;
      end
      if (ph == 7) begin
        lo = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
        hi = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
      end
      load_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      random_rays(60);
      // Long receiver hold-off in the first phase while requests keep
      // coming, so the block fills and pushes back on its input.
      if (ph == 0) hold_off_cycles <= 300;
      random_rays(80);
      // Pause the sender until every outstanding result has arrived.
      while (pending != 0) @(posedge clk);
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end

    // A long run with no idling on either side.
    random_rays(150);

    wait_drained();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Overall limit, generous against the slowest legal run.
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
